### sv/mxd_pkg.sv
// Shared types and constants for the modular exponent decoder.
`timescale 1ns / 1ps
package mxd_pkg;

  localparam int CFG_DATA_W = 32;
  localparam int PLAIN_W    = 32;
  localparam int CHAR_W     = 7;

  // Configuration register indexes
  typedef enum logic {
    REG_MODULUS  = 1'b0,
    REG_EXPONENT = 1'b1
  } reg_idx_t;

  // Modular multiply operations run on the shared datapath
  typedef enum logic [1:0] {
    OP_INIT = 2'd0,  // base * 1 mod n
    OP_ACC  = 2'd1,  // acc * base mod n
    OP_SQR  = 2'd2   // base * base mod n
  } op_t;

  typedef struct packed {
    logic load;    // capture item, acc = 1, exponent shifter loaded
    logic mul;     // form the full product and seed the remainder
    logic step;    // one restoring remainder step
    logic wb;      // write remainder back to acc or base
    logic shift;   // drop the consumed exponent bit
    logic finish;  // register the result item
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic exp_bit;
    logic exp_zero;
    logic n_small;
  } status_t;

  localparam logic [4:0]        SPACE_CODE    = 5'd27;
  localparam logic [CHAR_W-1:0] LETTER_OFFSET = 7'd96;
  localparam logic [CHAR_W-1:0] CHAR_SPACE    = 7'd32;
  localparam logic [CHAR_W-1:0] CHAR_OTHER    = 7'd35;

endpackage

### sv/mxd_ctrl.sv
// Sequencer for square-and-multiply over the exponent bits.
`timescale 1ns / 1ps
module mxd_ctrl #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  output logic             done,
  input  mxd_pkg::status_t status,
  output mxd_pkg::cmd_t    cmd
);
  import mxd_pkg::*;

  localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam logic [CW-1:0] LAST = CW'(WIDTH - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_RED,
    S_WB,
    S_NEXT
  } state_t;

  state_t        state;
  op_t           op;
  logic [CW-1:0] cnt;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd    = '0;
    cmd.op = op;
    case (state)
      S_IDLE: cmd.load = start;
      S_MUL:  cmd.mul  = 1'b1;
      S_RED:  cmd.step = 1'b1;
      S_WB: begin
        cmd.wb    = 1'b1;
        cmd.shift = (op == OP_SQR);
      end
      S_NEXT: cmd.finish = status.exp_zero || status.n_small;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_INIT;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op    <= OP_INIT;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          cnt   <= '0;
          state <= S_RED;
        end
        S_RED: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST) begin
            state <= S_WB;
          end
        end
        S_WB: begin
          // a multiply into acc is always followed by the squaring of base
          if (op == OP_ACC) begin
            op    <= OP_SQR;
            state <= S_MUL;
          end else begin
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (status.exp_zero || status.n_small) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            op    <= status.exp_bit ? OP_ACC : OP_SQR;
            state <= S_MUL;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_from_next: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_NEXT))
    else $error("result strobe without finishing step");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RED) |-> (cnt <= LAST))
    else $error("remainder step count out of range");

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == S_MUL) && (op == OP_INIT))
    else $error("accepted item did not begin base reduction");

endmodule

### sv/mxd_datapath.sv
// Operand registers, shared multiplier and serial remainder unit.
`timescale 1ns / 1ps
module mxd_datapath #(
  parameter int WIDTH     = 32,
  parameter int EXP_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  mxd_pkg::cmd_t                  cmd,
  output mxd_pkg::status_t               status,
  input  logic [WIDTH-1:0]               cipher_value,
  input  logic [WIDTH-1:0]               mod_n,
  input  logic [EXP_WIDTH-1:0]           exponent,
  output logic [mxd_pkg::PLAIN_W-1:0]    plain_value,
  output logic [mxd_pkg::CHAR_W-1:0]     decoded_char
);
  import mxd_pkg::*;

  logic [WIDTH-1:0]     base;
  logic [WIDTH-1:0]     acc;
  logic [EXP_WIDTH-1:0] exp_sh;
  logic [WIDTH-1:0]     rem;
  logic [WIDTH-1:0]     lo;

  logic [WIDTH-1:0]   mul_x;
  logic [WIDTH-1:0]   mul_y;
  logic [2*WIDTH-1:0] prod;
  logic [WIDTH:0]     trial;
  logic [WIDTH:0]     diff;
  logic [WIDTH-1:0]   final_val;
  logic [CHAR_W-1:0]  char_next;

  assign status.exp_bit  = exp_sh[0];
  assign status.exp_zero = (exp_sh == '0);
  assign status.n_small  = (mod_n[WIDTH-1:1] == '0);

  assign mul_x = (cmd.op == OP_ACC) ? acc : base;
  assign mul_y = (cmd.op == OP_INIT) ? WIDTH'(1) : base;
  assign prod  = (2*WIDTH)'(mul_x) * (2*WIDTH)'(mul_y);

  // restoring step: bring in the next product bit, subtract n if it fits
  assign trial = {rem, lo[WIDTH-1]};
  assign diff  = trial - {1'b0, mod_n};

  assign final_val = status.n_small ? '0 : acc;

  always_comb begin
    if (final_val == WIDTH'(SPACE_CODE)) begin
      char_next = CHAR_SPACE;
    end else if (final_val < WIDTH'(SPACE_CODE)) begin
      char_next = CHAR_W'(final_val[4:0]) + LETTER_OFFSET;
    end else begin
      char_next = CHAR_OTHER;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base   <= cipher_value;
      acc    <= WIDTH'(1);
      exp_sh <= exponent;
    end
    if (cmd.mul) begin
      rem <= prod[2*WIDTH-1:WIDTH];
      lo  <= prod[WIDTH-1:0];
    end
    if (cmd.step) begin
      rem <= (trial >= {1'b0, mod_n}) ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      lo  <= {lo[WIDTH-2:0], 1'b0};
    end
    if (cmd.wb) begin
      if (cmd.op == OP_ACC) begin
        acc <= rem;
      end else begin
        base <= rem;
      end
    end
    if (cmd.shift) begin
      exp_sh <= exp_sh >> 1;
    end
    if (cmd.finish) begin
      plain_value  <= PLAIN_W'(final_val);
      decoded_char <= char_next;
    end
  end

  a_rem_reduced: assert property (@(posedge clk) disable iff (rst)
    (cmd.wb && !status.n_small) |-> (rem < mod_n))
    else $error("remainder not reduced below modulus at write-back");

endmodule

### sv/modular_exponent_decoder.sv
// Top level: configuration registers, sequencer and modular datapath.
//
//   channel   | handshake                 | payload
//   ----------+---------------------------+----------------------------------
//   input     | start, busy               | cipher_value
//   result    | done (one-cycle strobe)   | plain_value, decoded_char
//   config    | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
// An item is taken when start is high and busy is low. Each modular multiply
// uses the shared WIDTH x WIDTH multiplier once, then WIDTH restoring
// remainder steps. An item first reduces the base; then, for each exponent bit
// up to the highest set one, it multiplies the base into acc when the bit is
// set and then squares the base. Busy is low again while done is high.
// Reset restores modulus 2 and exponent 1. Results cannot be held off; done
// is a one-cycle strobe with the result fields registered alongside it.
`timescale 1ns / 1ps
module modular_exponent_decoder #(
  parameter int WIDTH     = 32,
  parameter int EXP_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [WIDTH-1:0]                cipher_value,
  output logic                            done,
  output logic [mxd_pkg::PLAIN_W-1:0]     plain_value,
  output logic [mxd_pkg::CHAR_W-1:0]      decoded_char,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  mxd_pkg::reg_idx_t               cfg_index,
  input  logic [mxd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mxd_pkg::*;

  logic [WIDTH-1:0]     mod_n;
  logic [EXP_WIDTH-1:0] exponent;
  cmd_t                 cmd;
  status_t              status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_n    <= WIDTH'(2);
      exponent <= EXP_WIDTH'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODULUS:  mod_n    <= cfg_data[WIDTH-1:0];
        REG_EXPONENT: exponent <= cfg_data[EXP_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  mxd_ctrl #(
    .WIDTH (WIDTH)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .status (status),
    .cmd    (cmd)
  );

  mxd_datapath #(
    .WIDTH     (WIDTH),
    .EXP_WIDTH (EXP_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cipher_value (cipher_value),
    .mod_n        (mod_n),
    .exponent     (exponent),
    .plain_value  (plain_value),
    .decoded_char (decoded_char)
  );

endmodule

### dv/tb_top.sv
// Testbench for modular_exponent_decoder: random and directed ciphertexts checked against a predictor.
`timescale 1ns / 1ps
module tb_top;
  import mxd_pkg::*;

  localparam int WIDTH       = 32;
  localparam int EXP_WIDTH   = 32;
  localparam int CYCLE_LIMIT = 8_000_000;
  localparam int TAIL_CYCLES = 120;
  localparam int RANDOM_ITEMS = 430;

  typedef struct {
    logic [WIDTH-1:0]   cipher;
    logic [PLAIN_W-1:0] plain;
    logic [CHAR_W-1:0]  chr;
  } due_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [WIDTH-1:0]      cipher_value = '0;
  logic                  done;
  logic [PLAIN_W-1:0]    plain_value;
  logic [CHAR_W-1:0]     decoded_char;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  reg_idx_t              cfg_index = REG_MODULUS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // shadow of the block's registers, reset values
  logic [WIDTH-1:0]      modulus_shadow = 2;
  logic [EXP_WIDTH-1:0]  exponent_shadow = 1;

  logic [WIDTH-1:0] cipher_queue[$];
  due_t             due_results[$];
  due_t             got_due;

  int unsigned issued_count = 0;
  int unsigned accepted_count = 0;
  int unsigned checked_count = 0;
  int unsigned error_count = 0;
  int unsigned cfg_writes = 0;
  int unsigned settings_count = 0;
  int unsigned gap_left = 0;
  int unsigned cycle_count = 0;
  int unsigned letter_hits = 0;
  int unsigned space_hits = 0;
  int unsigned other_hits = 0;
  bit          fire;

  modular_exponent_decoder #(
    .WIDTH(WIDTH),
    .EXP_WIDTH(EXP_WIDTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cipher_value(cipher_value),
    .done(done),
    .plain_value(plain_value),
    .decoded_char(decoded_char),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // right-to-left square and multiply, reduced after every multiply
  function automatic logic [PLAIN_W-1:0] predict_plain(logic [WIDTH-1:0] a,
                                                      logic [EXP_WIDTH-1:0] k,
                                                      logic [WIDTH-1:0] n);
    logic [63:0] base;
    logic [63:0] acc;
    if (n < 2) return '0;
    base = 64'(a) % 64'(n);
    acc = 64'd1;
    for (int i = 0; i < EXP_WIDTH; i++) begin
      if (k[i]) acc = (acc * base) % 64'(n);
      base = (base * base) % 64'(n);
    end
    return acc[PLAIN_W-1:0];
  endfunction

  function automatic logic [CHAR_W-1:0] char_for(logic [PLAIN_W-1:0] p);
    if (p == PLAIN_W'(SPACE_CODE)) return CHAR_SPACE;
    else if (p < PLAIN_W'(SPACE_CODE)) return LETTER_OFFSET + p[CHAR_W-1:0];
    else return CHAR_OTHER;
  endfunction

  // mostly back to back, now and then a long pause
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 85) return $urandom_range(1, 4);
    else if (r < 95) return $urandom_range(5, 40);
    else return $urandom_range(41, 2500);
  endfunction

  function automatic logic [WIDTH-1:0] pick_cipher(logic [WIDTH-1:0] n);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 1;
      2: return '1;
      3: return n - 1;
      4, 5: return $urandom_range(0, 63);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [WIDTH-1:0] pick_modulus();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return 1;
      2, 3: return '1;
      4, 5, 6, 7, 8, 9: return $urandom_range(2, 64);
      10, 11: return $urandom | 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // driver: hold start until the block takes the item, then idle or advance
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      fire = start && !busy;
      if (fire) begin
        got_due.cipher = cipher_value;
        got_due.plain = predict_plain(cipher_value, exponent_shadow, modulus_shadow);
        got_due.chr = char_for(got_due.plain);
        due_results.push_back(got_due);
        accepted_count++;
      end
      if (start && !fire) begin
        // hold
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cipher_queue.size() != 0) begin
        cipher_value <= cipher_queue.pop_front();
        start <= 1'b1;
        issued_count++;
        gap_left = pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] seen,
                                 logic [WIDTH-1:0] cipher);
    error_count++;
    if (error_count <= 10)
      $display("mismatch on %s: cipher %h n %h k %h expected %h got %h", what, cipher,
               modulus_shadow, exponent_shadow, want, seen);
  endtask

  // monitor: every done strobe is checked against the oldest expectation
  due_t want_due;
  always @(posedge clk) begin
    if (!rst && done) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected result", '0, plain_value, '0);
      end else begin
        want_due = due_results.pop_front();
        checked_count++;
        if (plain_value !== want_due.plain)
          report_mismatch("plain_value", want_due.plain, plain_value, want_due.cipher);
        if (decoded_char !== want_due.chr)
          report_mismatch("decoded_char", 32'(want_due.chr), 32'(decoded_char),
                          want_due.cipher);
        if (want_due.chr == CHAR_SPACE) space_hits++;
        else if (want_due.chr == CHAR_OTHER) other_hits++;
        else letter_hits++;
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_MODULUS) modulus_shadow = val[WIDTH-1:0];
    else exponent_shadow = val[EXP_WIDTH-1:0];
    cfg_writes++;
  endtask

  // pause the sender until every accepted item has produced its result
  task automatic wait_idle();
    while (cipher_queue.size() != 0 || issued_count != accepted_count ||
           due_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_regs(logic [WIDTH-1:0] n, logic [EXP_WIDTH-1:0] k);
    wait_idle();
    write_reg(REG_MODULUS, n);
    write_reg(REG_EXPONENT, k);
    settings_count++;
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             due_results.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int unsigned random_items;
    int unsigned batch;
    int unsigned char_ciphers[7];
    logic [WIDTH-1:0]     n;
    logic [EXP_WIDTH-1:0] k;
    random_items = 0;
    char_ciphers = '{0, 1, 26, 27, 28, 30, 58};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset values: modulus 2, exponent 1
    settings_count++;
    cipher_queue.push_back('0);
    cipher_queue.push_back(1);
    cipher_queue.push_back('1);

    // every character class: letters, space, other
    set_regs(31, 1);
    foreach (char_ciphers[i])
      cipher_queue.push_back(char_ciphers[i]);

    // zero exponent, including zero to the zero
    set_regs('1, 0);
    cipher_queue.push_back('0);
    cipher_queue.push_back(5);

    // degenerate moduli
    set_regs(1, 3);
    cipher_queue.push_back(7);
    cipher_queue.push_back('1);
    set_regs(0, 3);
    cipher_queue.push_back(7);
    cipher_queue.push_back('1);

    // full width on everything
    set_regs('1, '1);
    cipher_queue.push_back(32'hFFFF_FFFE);
    cipher_queue.push_back(32'h8000_0000);
    cipher_queue.push_back(2);

    set_regs(32'h8000_0000, 2);
    cipher_queue.push_back('1);
    cipher_queue.push_back(32'h1234_5678);

    while (random_items < RANDOM_ITEMS) begin
      n = pick_modulus();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: k = $urandom_range(0, 255);
        6, 7, 8: k = $urandom_range(256, 65535);
        default: k = $urandom | 32'h8000_0000;
      endcase
      // long exponents are slow, keep those batches short
      batch = k[EXP_WIDTH-1] ? 6 : $urandom_range(15, 40);
      wait_idle();
      if ($urandom_range(0, 3) != 0 || settings_count < 12) begin
        write_reg(REG_MODULUS, n);
        write_reg(REG_EXPONENT, k);
      end else if ($urandom_range(0, 1) != 0) begin
        write_reg(REG_MODULUS, n);
      end else begin
        write_reg(REG_EXPONENT, k);
      end
      settings_count++;
      repeat (batch) cipher_queue.push_back(pick_cipher(modulus_shadow));
      random_items += batch;
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (due_results.size() != 0) begin
      error_count++;
      $display("%0d expected results never arrived", due_results.size());
    end

    $display("covered %0d ciphertexts under %0d register settings (%0d writes), %0d checked",
             accepted_count, settings_count, cfg_writes, checked_count);
    $display("characters seen: %0d letters, %0d spaces, %0d other; %0d errors",
             letter_hits, space_hits, other_hits, error_count);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
